/* src/ttf_pkg.sv */
// Package for the triangle tangent frame block: payload structs, state and op codes,
// and the command and status groups that pass between controller and datapath.
// No dependencies.
package ttf_pkg;

    localparam int OUT_FRAC_BITS = 14;
    localparam int MAG_W         = 51;                  // magnitude of one raw vector component
    localparam int NRM_W         = 30;                  // magnitude after the normalising shift
    localparam int REM_W         = NRM_W + OUT_FRAC_BITS + 3;
    localparam int Q_W           = 16;

    typedef struct packed {
        logic [23:0]        vertex_id;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] tex_u;
        logic signed [15:0] tex_v;
    } t_in;

    typedef struct packed {
        logic [23:0]        out_vertex_id;
        logic signed [15:0] tangent_x;
        logic signed [15:0] tangent_y;
        logic signed [15:0] tangent_z;
        logic signed [15:0] bitangent_x;
        logic signed [15:0] bitangent_y;
        logic signed [15:0] bitangent_z;
        logic               degenerate;
        logic               last_of_triangle;
    } t_out;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DIFF, ST_MUL, ST_ACC, ST_CHECK, ST_DETZERO, ST_ABS, ST_SHIFT,
        ST_SQ, ST_SQACC, ST_SQRT, ST_DIVINIT, ST_DIV, ST_DIVEND, ST_VZERO, ST_NEXTV,
        ST_EMIT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_DIFF, OP_MUL, OP_ACC, OP_DETZERO, OP_ABS, OP_SHIFT,
        OP_SQ, OP_SQACC, OP_SQRT, OP_DIVINIT, OP_DIV, OP_DIVEND, OP_VZERO
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [3:0] j;       // product index, 0..13
        logic [1:0] k;       // component or result index
        logic       n;       // 0 tangent, 1 bitangent
        logic [4:0] step;    // iteration count of the root and divide loops
        logic [1:0] corner;  // corner being loaded
    } t_cmd;

    typedef struct packed {
        logic det_zero;
        logic need_shift;
        logic all_zero;
        logic root_zero;
    } t_sts;

endpackage

/* src/ttf_ctrl.sv */
// Controller for the triangle tangent frame block: sequences loading, products,
// normalisation and result delivery. Depends on ttf_pkg.
module ttf_ctrl import ttf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_out_stall,
    input  t_sts i_sts,
    output logic o_in_stall,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    t_state     r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    logic [3:0] r_j, n_j;
    logic [1:0] r_k, n_k;
    logic       r_n, n_n;
    logic [1:0] r_corner, n_corner;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_j      <= '0;
            r_k      <= '0;
            r_n      <= 1'b0;
            r_corner <= '0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_j      <= n_j;
            r_k      <= n_k;
            r_n      <= n_n;
            r_corner <= n_corner;
        end
    end

    // Next state and loop counters.
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_j      = r_j;
        n_k      = r_k;
        n_n      = r_n;
        n_corner = r_corner;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (r_corner == 2'd2) begin
                        n_state = ST_DIFF;
                    end else begin
                        n_corner = r_corner + 2'd1;
                    end
                end
            end
            ST_DIFF: begin
                n_j     = '0;
                n_state = ST_MUL;
            end
            ST_MUL: n_state = ST_ACC;
            ST_ACC: begin
                if (r_j == 4'd13) begin
                    n_state = ST_CHECK;
                end else begin
                    n_j     = r_j + 4'd1;
                    n_state = ST_MUL;
                end
            end
            ST_CHECK: begin
                n_n = 1'b0;
                n_k = '0;
                n_state = i_sts.det_zero ? ST_DETZERO : ST_ABS;
            end
            ST_DETZERO: begin
                n_k     = '0;
                n_state = ST_EMIT;
            end
            ST_ABS: n_state = ST_SHIFT;
            ST_SHIFT: begin
                if (!i_sts.need_shift) begin
                    n_k     = '0;
                    n_state = i_sts.all_zero ? ST_VZERO : ST_SQ;
                end
            end
            ST_SQ: n_state = ST_SQACC;
            ST_SQACC: begin
                if (r_k == 2'd2) begin
                    n_cnt   = 5'd31;
                    n_state = ST_SQRT;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = ST_SQ;
                end
            end
            ST_SQRT: begin
                if (r_cnt == 5'd0) begin
                    n_k     = '0;
                    n_state = ST_DIVINIT;
                end else begin
                    n_cnt = r_cnt - 5'd1;
                end
            end
            ST_DIVINIT: begin
                // The root is complete here, so a zero length is judged now.
                if (i_sts.root_zero) begin
                    n_state = ST_VZERO;
                end else begin
                    n_cnt   = 5'd15;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_cnt == 5'd0) begin
                    n_state = ST_DIVEND;
                end else begin
                    n_cnt = r_cnt - 5'd1;
                end
            end
            ST_DIVEND: begin
                if (r_k == 2'd2) begin
                    n_state = ST_NEXTV;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = ST_DIVINIT;
                end
            end
            ST_VZERO: n_state = ST_NEXTV;
            ST_NEXTV: begin
                n_k = '0;
                if (!r_n) begin
                    n_n     = 1'b1;
                    n_state = ST_ABS;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!i_out_stall) begin
                    if (r_k == 2'd2) begin
                        n_corner = '0;
                        n_state  = ST_IDLE;
                    end else begin
                        n_k = r_k + 2'd1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs and datapath commands.
    always_comb begin
        o_in_stall    = (r_state != ST_IDLE);
        o_out_valid   = (r_state == ST_EMIT);
        o_cmd.j       = r_j;
        o_cmd.k       = r_k;
        o_cmd.n       = r_n;
        o_cmd.step    = r_cnt;
        o_cmd.corner  = r_corner;
        case (r_state)
            ST_IDLE:    o_cmd.op = i_in_valid ? OP_LOAD : OP_NONE;
            ST_DIFF:    o_cmd.op = OP_DIFF;
            ST_MUL:     o_cmd.op = OP_MUL;
            ST_ACC:     o_cmd.op = OP_ACC;
            ST_DETZERO: o_cmd.op = OP_DETZERO;
            ST_ABS:     o_cmd.op = OP_ABS;
            ST_SHIFT:   o_cmd.op = i_sts.need_shift ? OP_SHIFT : OP_NONE;
            ST_SQ:      o_cmd.op = OP_SQ;
            ST_SQACC:   o_cmd.op = OP_SQACC;
            ST_SQRT:    o_cmd.op = OP_SQRT;
            ST_DIVINIT: o_cmd.op = OP_DIVINIT;
            ST_DIV:     o_cmd.op = OP_DIV;
            ST_DIVEND:  o_cmd.op = OP_DIVEND;
            ST_VZERO:   o_cmd.op = OP_VZERO;
            default:    o_cmd.op = OP_NONE;
        endcase
    end

    a_emit_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall) else $error("input taken while results pending");
    a_emit_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_k != 2'd3)) else $error("result index out of range");
    a_emit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && r_k == 2'd2 && !i_out_stall)
        |=> (r_state == ST_IDLE && r_corner == 2'd0))
        else $error("triangle not closed after third result");
    a_corner_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_corner != 2'd3)) else $error("corner count out of range");

endmodule

/* src/ttf_dp.sv */
// Datapath for the triangle tangent frame block: corner store, shared product unit,
// normalising shift, bit-serial square root and restoring divider. Depends on ttf_pkg.
module ttf_dp import ttf_pkg::*; (
    input  logic i_clk,
    input  t_cmd i_cmd,
    input  t_in  i_data,
    output t_sts o_sts,
    output t_out o_data
);

    logic signed [31:0]     r_pos [2][3];
    logic signed [15:0]     r_uv  [2][2];
    logic [23:0]            r_id  [2];
    logic signed [31:0]     r_p2  [3];
    logic signed [15:0]     r_uv2 [2];
    logic [23:0]            r_id2;
    logic signed [32:0]     r_e1 [3];
    logic signed [32:0]     r_e2 [3];
    logic signed [16:0]     r_du1, r_dv1, r_du2, r_dv2;
    logic signed [49:0]     r_prod;
    logic signed [49:0]     r_acc;
    logic signed [MAG_W-1:0] r_det;
    logic signed [MAG_W-1:0] r_vec [6];
    logic [MAG_W-1:0]       r_mag [3];
    logic                   r_neg [3];
    logic [2*NRM_W-1:0]     r_sq;
    logic [63:0]            r_sum;
    logic [63:0]            r_root;
    logic [REM_W-1:0]       r_rem;
    logic [Q_W-1:0]         r_quo;
    logic signed [15:0]     r_q [2][3];
    logic                   r_degen;

    logic signed [16:0]     mul_a;
    logic signed [32:0]     mul_b;
    logic [2:0]             pair;
    logic [1:0]             comp;
    logic signed [MAG_W-1:0] acc_diff;
    logic [2:0]             vec_base;
    logic [63:0]            sq_bit;
    logic [63:0]            sq_trial;
    logic [REM_W-1:0]       div_trial;
    logic [Q_W-1:0]         quo_sat;

    // Operand selection for the shared 17 x 33 multiplier.
    always_comb begin
        pair = i_cmd.j[3:1];
        comp = 2'd0;
        mul_a = r_du1;
        mul_b = 33'(r_dv2);
        if (pair == 3'd0) begin
            mul_a = i_cmd.j[0] ? r_du2 : r_du1;
            mul_b = i_cmd.j[0] ? 33'(r_dv1) : 33'(r_dv2);
        end else if (pair <= 3'd3) begin
            comp  = 2'(pair - 3'd1);
            mul_a = i_cmd.j[0] ? r_dv1 : r_dv2;
            mul_b = i_cmd.j[0] ? r_e2[comp] : r_e1[comp];
        end else begin
            comp  = 2'(pair - 3'd4);
            mul_a = i_cmd.j[0] ? r_du2 : r_du1;
            mul_b = i_cmd.j[0] ? r_e1[comp] : r_e2[comp];
        end
    end

    assign acc_diff  = MAG_W'(r_acc) - MAG_W'(r_prod);
    assign vec_base  = i_cmd.n ? 3'd3 : 3'd0;
    assign sq_bit    = 64'd1 << {i_cmd.step, 1'b0};
    assign sq_trial  = r_root + sq_bit;
    assign div_trial = REM_W'(r_root[31:0]) << i_cmd.step[3:0];
    assign quo_sat   = (r_quo > Q_W'(32767)) ? Q_W'(32767) : r_quo;

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                if (i_cmd.corner == 2'd2) begin
                    r_p2[0] <= i_data.pos_x;
                    r_p2[1] <= i_data.pos_y;
                    r_p2[2] <= i_data.pos_z;
                    r_uv2[0] <= i_data.tex_u;
                    r_uv2[1] <= i_data.tex_v;
                    r_id2    <= i_data.vertex_id;
                end else begin
                    r_pos[i_cmd.corner[0]][0] <= i_data.pos_x;
                    r_pos[i_cmd.corner[0]][1] <= i_data.pos_y;
                    r_pos[i_cmd.corner[0]][2] <= i_data.pos_z;
                    r_uv[i_cmd.corner[0]][0]  <= i_data.tex_u;
                    r_uv[i_cmd.corner[0]][1]  <= i_data.tex_v;
                    r_id[i_cmd.corner[0]]     <= i_data.vertex_id;
                end
            end
            OP_DIFF: begin
                for (int c = 0; c < 3; c++) begin
                    r_e1[c] <= 33'(r_pos[1][c]) - 33'(r_pos[0][c]);
                    r_e2[c] <= 33'(r_p2[c]) - 33'(r_pos[0][c]);
                end
                r_du1   <= 17'(r_uv[1][0]) - 17'(r_uv[0][0]);
                r_dv1   <= 17'(r_uv[1][1]) - 17'(r_uv[0][1]);
                r_du2   <= 17'(r_uv2[0]) - 17'(r_uv[0][0]);
                r_dv2   <= 17'(r_uv2[1]) - 17'(r_uv[0][1]);
                r_degen <= 1'b0;
            end
            OP_MUL: r_prod <= 50'(mul_a * mul_b);
            OP_ACC: begin
                if (!i_cmd.j[0]) begin
                    r_acc <= r_prod;
                end else if (pair == 3'd0) begin
                    r_det <= acc_diff;
                end else begin
                    r_vec[pair - 3'd1] <= acc_diff;
                end
            end
            OP_DETZERO: begin
                for (int c = 0; c < 3; c++) begin
                    r_q[0][c] <= '0;
                    r_q[1][c] <= '0;
                end
                r_degen <= 1'b1;
            end
            OP_ABS: begin
                for (int c = 0; c < 3; c++) begin
                    r_neg[c] <= r_vec[vec_base + 3'(c)][MAG_W-1] ^ r_det[MAG_W-1];
                    r_mag[c] <= r_vec[vec_base + 3'(c)][MAG_W-1]
                              ? MAG_W'(-r_vec[vec_base + 3'(c)])
                              : MAG_W'(r_vec[vec_base + 3'(c)]);
                end
                r_sum  <= '0;
                r_root <= '0;
            end
            OP_SHIFT: begin
                for (int c = 0; c < 3; c++) r_mag[c] <= r_mag[c] >> 1;
            end
            OP_SQ: r_sq <= r_mag[i_cmd.k][NRM_W-1:0] * r_mag[i_cmd.k][NRM_W-1:0];
            OP_SQACC: r_sum <= r_sum + 64'(r_sq);
            OP_SQRT: begin
                if (r_sum >= sq_trial) begin
                    r_sum  <= r_sum - sq_trial;
                    r_root <= (r_root >> 1) + sq_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
            end
            OP_DIVINIT: begin
                r_rem <= (REM_W'(r_mag[i_cmd.k][NRM_W-1:0]) << OUT_FRAC_BITS)
                       + REM_W'(r_root[31:1]);
                r_quo <= '0;
            end
            OP_DIV: begin
                if (r_rem >= div_trial) begin
                    r_rem <= r_rem - div_trial;
                    r_quo[i_cmd.step[3:0]] <= 1'b1;
                end
            end
            OP_DIVEND: begin
                r_q[i_cmd.n][i_cmd.k] <= r_neg[i_cmd.k] ? 16'(-quo_sat) : 16'(quo_sat);
            end
            OP_VZERO: begin
                for (int c = 0; c < 3; c++) r_q[i_cmd.n][c] <= '0;
                r_degen <= 1'b1;
            end
            default: ;
        endcase
    end

    always_comb begin
        o_sts.det_zero   = (r_det == '0);
        o_sts.need_shift = (|r_mag[0][MAG_W-1:NRM_W]) | (|r_mag[1][MAG_W-1:NRM_W])
                         | (|r_mag[2][MAG_W-1:NRM_W]);
        o_sts.all_zero   = (r_mag[0] == '0) && (r_mag[1] == '0) && (r_mag[2] == '0);
        o_sts.root_zero  = (r_root == '0);
    end

    always_comb begin
        case (i_cmd.k)
            2'd0:    o_data.out_vertex_id = r_id[0];
            2'd1:    o_data.out_vertex_id = r_id[1];
            default: o_data.out_vertex_id = r_id2;
        endcase
        o_data.tangent_x        = r_q[0][0];
        o_data.tangent_y        = r_q[0][1];
        o_data.tangent_z        = r_q[0][2];
        o_data.bitangent_x      = r_q[1][0];
        o_data.bitangent_y      = r_q[1][1];
        o_data.bitangent_z      = r_q[1][2];
        o_data.degenerate       = r_degen;
        o_data.last_of_triangle = (i_cmd.k == 2'd2);
    end

endmodule

/* src/triangle_tangent_frame_top.sv */
// Top level of the triangle tangent frame block: joins controller and datapath.
// Depends on ttf_pkg, ttf_ctrl and ttf_dp.
//
//   Channel   Direction  Handshake                    Payload
//   input     in         i_in_valid / o_in_stall      i_in_data  (t_in, one corner)
//   output    out        o_out_valid / i_out_stall    o_out_data (t_out, one corner frame)
//
// The first two corners of a triangle are only held. The third corner starts the work:
// 14 products through one shared multiplier, then per vector a normalising shift, three
// squares, a bit-serial square root and three divisions. The three results then follow
// one per cycle unless the receiver stalls; no request is taken from the third corner
// until the last result has gone.
// Reset clears the controller only; the corner store needs none.
module triangle_tangent_frame_top import ttf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    t_cmd cmd;
    t_sts sts;

    // Sequencer: decides which datapath step runs each cycle.
    ttf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    // Arithmetic and storage; results are held in registers while stalled.
    ttf_dp u_dp (
        .i_clk  (i_clk),
        .i_cmd  (cmd),
        .i_data (i_in_data),
        .o_sts  (sts),
        .o_data (o_out_data)
    );

endmodule

/* bench/tb.sv */
// Self-checking testbench for triangle_tangent_frame_top: drives triangle corners
// and compares each corner's tangent frame against an in-bench fixed-point predictor.
// Depends on ttf_pkg and the RTL of triangle_tangent_frame_top.
module tb import ttf_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NORM_FRAC = 14;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_in  i_in_data;
    logic o_out_valid;
    logic i_out_stall;
    t_out o_out_data;

    triangle_tangent_frame_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // Corners waiting to be sent, and corner frames waiting to come back.
    t_in  pending_corners[$];
    t_out expected_frames[$];

    // Predictor copy of the corner store.
    t_in  held_corner[2];
    int   held_count;

    int   error_count;
    int   frames_seen;
    int   degenerate_seen;
    int   corners_sent;
    int   sender_idle_pct;
    int   receiver_idle_pct;
    bit   stimulus_done;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Integer square root, floor, by the usual bit-pair method.
    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned root;
        longint unsigned bit_val;
        root    = 0;
        bit_val = 64'd1 << 62;
        while (bit_val > x) bit_val = bit_val >> 2;
        while (bit_val != 0) begin
            if (x >= root + bit_val) begin
                x    = x - (root + bit_val);
                root = (root >> 1) + bit_val;
            end else begin
                root = root >> 1;
            end
            bit_val = bit_val >> 2;
        end
        return root;
    endfunction

    // Scales a raw vector to unit length in Q1.14; returns 0 when its length is zero.
    function automatic bit unit_vector(input longint vec[3], output logic signed [15:0] q[3]);
        longint unsigned mag[3];
        longint unsigned biggest;
        longint unsigned sum_sq;
        longint unsigned len;
        longint unsigned ratio;
        bit              neg[3];
        int              shift;
        biggest = 0;
        sum_sq  = 0;
        shift   = 0;
        for (int k = 0; k < 3; k++) begin
            neg[k] = vec[k] < 0;
            mag[k] = neg[k] ? longint'(-vec[k]) : longint'(vec[k]);
            if (mag[k] > biggest) biggest = mag[k];
            q[k] = '0;
        end
        if (biggest == 0) return 1'b0;
        while ((biggest >> shift) >= (64'd1 << 30)) shift++;
        for (int k = 0; k < 3; k++) begin
            mag[k] = mag[k] >> shift;
            sum_sq += mag[k] * mag[k];
        end
        len = int_sqrt(sum_sq);
        if (len == 0) return 1'b0;
        for (int k = 0; k < 3; k++) begin
            ratio = ((mag[k] << NORM_FRAC) + (len >> 1)) / len;
            if (ratio > 32767) ratio = 32767;
            q[k] = neg[k] ? -16'(ratio) : 16'(ratio);
        end
        return 1'b1;
    endfunction

    // Takes one accepted corner; on the third of a triangle it queues three frames.
    task automatic predict_tangent_frame(input t_in corner);
        longint e1[3], e2[3], tan_raw[3], bit_raw[3];
        longint du1, dv1, du2, dv2, det;
        logic signed [15:0] tan_q[3], bit_q[3];
        logic [23:0] ids[3];
        bit   degen;
        t_out frame;
        if (held_count < 2) begin
            held_corner[held_count] = corner;
            held_count++;
            return;
        end
        e1[0] = longint'(held_corner[1].pos_x) - longint'(held_corner[0].pos_x);
        e1[1] = longint'(held_corner[1].pos_y) - longint'(held_corner[0].pos_y);
        e1[2] = longint'(held_corner[1].pos_z) - longint'(held_corner[0].pos_z);
        e2[0] = longint'(corner.pos_x) - longint'(held_corner[0].pos_x);
        e2[1] = longint'(corner.pos_y) - longint'(held_corner[0].pos_y);
        e2[2] = longint'(corner.pos_z) - longint'(held_corner[0].pos_z);
        du1 = longint'(held_corner[1].tex_u) - longint'(held_corner[0].tex_u);
        dv1 = longint'(held_corner[1].tex_v) - longint'(held_corner[0].tex_v);
        du2 = longint'(corner.tex_u) - longint'(held_corner[0].tex_u);
        dv2 = longint'(corner.tex_v) - longint'(held_corner[0].tex_v);
        det = du1 * dv2 - du2 * dv1;
        degen = 1'b0;
        for (int k = 0; k < 3; k++) begin
            tan_q[k] = '0;
            bit_q[k] = '0;
        end
        if (det == 0) begin
            degen = 1'b1;
        end else begin
            // Only the sign of the determinant matters, as both vectors are normalised.
            for (int k = 0; k < 3; k++) begin
                tan_raw[k] = dv2 * e1[k] - dv1 * e2[k];
                bit_raw[k] = du1 * e2[k] - du2 * e1[k];
                if (det < 0) begin
                    tan_raw[k] = -tan_raw[k];
                    bit_raw[k] = -bit_raw[k];
                end
            end
            if (!unit_vector(tan_raw, tan_q)) degen = 1'b1;
            if (!unit_vector(bit_raw, bit_q)) degen = 1'b1;
        end
        ids[0] = held_corner[0].vertex_id;
        ids[1] = held_corner[1].vertex_id;
        ids[2] = corner.vertex_id;
        for (int r = 0; r < 3; r++) begin
            frame.out_vertex_id    = ids[r];
            frame.tangent_x        = tan_q[0];
            frame.tangent_y        = tan_q[1];
            frame.tangent_z        = tan_q[2];
            frame.bitangent_x      = bit_q[0];
            frame.bitangent_y      = bit_q[1];
            frame.bitangent_z      = bit_q[2];
            frame.degenerate       = degen;
            frame.last_of_triangle = (r == 2);
            expected_frames.push_back(frame);
        end
        held_count = 0;
    endtask

    // Random corner; positions are sometimes kept small so that the shift stage is idle.
    function automatic t_in random_corner();
        t_in c;
        c.vertex_id = 24'($urandom);
        if ($urandom_range(0, 2) == 0) begin
            c.pos_x = 32'($urandom_range(0, 2047)) - 32'sd1024;
            c.pos_y = 32'($urandom_range(0, 2047)) - 32'sd1024;
            c.pos_z = 32'($urandom_range(0, 2047)) - 32'sd1024;
        end else begin
            c.pos_x = $urandom;
            c.pos_y = $urandom;
            c.pos_z = $urandom;
        end
        c.tex_u = 16'($urandom);
        c.tex_v = 16'($urandom);
        return c;
    endfunction

    function automatic t_in make_corner(input logic [23:0] id, input int px, input int py,
                                        input int pz, input int tu, input int tv);
        t_in c;
        c.vertex_id = id;
        c.pos_x     = px;
        c.pos_y     = py;
        c.pos_z     = pz;
        c.tex_u     = 16'(tu);
        c.tex_v     = 16'(tv);
        return c;
    endfunction

    // Driver: presents the next pending request, holding it while the block stalls.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predict_tangent_frame(i_in_data);
                corners_sent++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_corners.size() != 0 &&
                    $urandom_range(0, 99) >= sender_idle_pct) begin
                    i_in_data  <= pending_corners.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted frame against the oldest expectation.
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                frames_seen++;
                if (expected_frames.size() == 0) begin
                    $error("unexpected frame for vertex %0d", o_out_data.out_vertex_id);
                    error_count++;
                end else begin
                    want = expected_frames.pop_front();
                    if (want.degenerate) degenerate_seen++;
                    if (o_out_data.out_vertex_id !== want.out_vertex_id) begin
                        $error("out_vertex_id: expected %0d, got %0d",
                               want.out_vertex_id, o_out_data.out_vertex_id);
                        error_count++;
                    end
                    if (o_out_data.tangent_x !== want.tangent_x) begin
                        $error("tangent_x: expected %0d, got %0d",
                               want.tangent_x, o_out_data.tangent_x);
                        error_count++;
                    end
                    if (o_out_data.tangent_y !== want.tangent_y) begin
                        $error("tangent_y: expected %0d, got %0d",
                               want.tangent_y, o_out_data.tangent_y);
                        error_count++;
                    end
                    if (o_out_data.tangent_z !== want.tangent_z) begin
                        $error("tangent_z: expected %0d, got %0d",
                               want.tangent_z, o_out_data.tangent_z);
                        error_count++;
                    end
                    if (o_out_data.bitangent_x !== want.bitangent_x) begin
                        $error("bitangent_x: expected %0d, got %0d",
                               want.bitangent_x, o_out_data.bitangent_x);
                        error_count++;
                    end
                    if (o_out_data.bitangent_y !== want.bitangent_y) begin
                        $error("bitangent_y: expected %0d, got %0d",
                               want.bitangent_y, o_out_data.bitangent_y);
                        error_count++;
                    end
                    if (o_out_data.bitangent_z !== want.bitangent_z) begin
                        $error("bitangent_z: expected %0d, got %0d",
                               want.bitangent_z, o_out_data.bitangent_z);
                        error_count++;
                    end
                    if (o_out_data.degenerate !== want.degenerate) begin
                        $error("degenerate: expected %0d, got %0d",
                               want.degenerate, o_out_data.degenerate);
                        error_count++;
                    end
                    if (o_out_data.last_of_triangle !== want.last_of_triangle) begin
                        $error("last_of_triangle: expected %0d, got %0d",
                               want.last_of_triangle, o_out_data.last_of_triangle);
                        error_count++;
                    end
                end
            end
            i_out_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
        end
    end

    // Stimulus: directed triangles first, then three phases of random triangles with
    // different idling mixes. The driver empties the queue; a phase ends once it has.
    initial begin
        int seen_at_end;
        error_count       = 0;
        frames_seen       = 0;
        degenerate_seen   = 0;
        corners_sent      = 0;
        held_count        = 0;
        stimulus_done     = 1'b0;
        sender_idle_pct   = 38;
        receiver_idle_pct = 82;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_out_stall = 1'b0;
        i_in_data   = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // A plain right-angled triangle with unit UVs.
        pending_corners.push_back(make_corner(24'd0, 0, 0, 0, 0, 0));
        pending_corners.push_back(make_corner(24'd1, 32'h10000, 0, 0, 4096, 0));
        pending_corners.push_back(make_corner(24'hFFFFFF, 0, 32'h10000, 0, 0, 4096));
        // Mirrored UVs, so the determinant is negative.
        pending_corners.push_back(make_corner(24'd5, 0, 0, 0, 0, 0));
        pending_corners.push_back(make_corner(24'd6, 32'h10000, 0, 0, 0, 4096));
        pending_corners.push_back(make_corner(24'd7, 0, 0, 32'h10000, 4096, 0));
        // Collinear UVs: zero determinant.
        pending_corners.push_back(make_corner(24'd8, 100, 200, 300, 10, 10));
        pending_corners.push_back(make_corner(24'd9, 400, 0, 0, 20, 20));
        pending_corners.push_back(make_corner(24'd10, 0, 500, 0, 30, 30));
        // All corners at one point: both vectors have zero length.
        pending_corners.push_back(make_corner(24'd11, 77, 77, 77, 0, 0));
        pending_corners.push_back(make_corner(24'd12, 77, 77, 77, 4096, 0));
        pending_corners.push_back(make_corner(24'd13, 77, 77, 77, 0, 4096));
        // Position extremes with UV extremes: the widest products and the longest shift.
        pending_corners.push_back(make_corner(24'h800000, 32'h80000000, 32'h7FFFFFFF,
                                              32'h80000000, 16'h8000, 16'h8000));
        pending_corners.push_back(make_corner(24'h7FFFFF, 32'h7FFFFFFF, 32'h80000000,
                                              32'h7FFFFFFF, 16'h7FFF, 16'h8000));
        pending_corners.push_back(make_corner(24'h000001, 32'h80000000, 32'h80000000,
                                              32'h7FFFFFFF, 16'h8000, 16'h7FFF));
        // Only the tangent is null: second corner repeats the first in position.
        pending_corners.push_back(make_corner(24'd20, 5, 6, 7, 0, 0));
        pending_corners.push_back(make_corner(24'd21, 5, 6, 7, 4096, 0));
        pending_corners.push_back(make_corner(24'd22, 9, 6, 7, 0, 4096));
        // Tiny vectors of length one bit.
        pending_corners.push_back(make_corner(24'd30, -1, -1, -1, -1, -1));
        pending_corners.push_back(make_corner(24'd31, 0, -1, -1, 0, -1));
        pending_corners.push_back(make_corner(24'd32, -1, 0, -1, -1, 0));

        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                sender_idle_pct   = 82;
                receiver_idle_pct = 38;
            end else if (phase == 2) begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            for (int t = 0; t < 26; t++) begin
                for (int c = 0; c < 3; c++) begin
                    pending_corners.push_back(random_corner());
                end
            end
            wait (pending_corners.size() == 0);
        end
        wait (corners_sent == 21 + 3 * 26 * 3);
        stimulus_done = 1'b1;
        wait (expected_frames.size() == 0);
        repeat (300) @(posedge i_clk);

        $display("tb: %0d corners sent, %0d corner frames checked, %0d of them degenerate",
                 corners_sent, frames_seen, degenerate_seen);
        if (error_count == 0 && expected_frames.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    // Watchdog: about 90 triangles, heavily stalled.
    initial begin
        #2000000;
        $display("tb: timeout, %0d corner frames still expected", expected_frames.size());
        $display("tb: errors");
        $finish;
    end

endmodule

/* triangle_tangent_frame_top.f */
src/ttf_pkg.sv
src/ttf_ctrl.sv
src/ttf_dp.sv
src/triangle_tangent_frame_top.sv
bench/tb.sv
